[hdl/sdspi_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sdspi_pkg
// Types and constants shared by the SD card SPI-mode command engine.
// ----------------------------------------------------------------------------
package sdspi_pkg;

	// Command numbers that change the engine's behavior.
	localparam logic [5:0] CMD_GO_IDLE  = 6'd0;
	localparam logic [5:0] CMD_IF_COND  = 6'd8;
	localparam logic [5:0] CMD_STOP     = 6'd12;
	localparam logic [5:0] CMD_APP      = 6'd55;
	localparam logic [5:0] CMD_GET_OCR  = 6'd58;

	localparam logic [31:0] IF_COND_ARG = 32'h0000_01AA;

	localparam logic [7:0] FRAME_START = 8'h40;
	localparam logic [7:0] CRC_GO_IDLE = 8'h95;
	localparam logic [7:0] CRC_IF_COND = 8'h87;
	localparam logic [7:0] CRC_DUMMY   = 8'h01;
	localparam logic [7:0] FILL_BYTE   = 8'hFF;

	// Command frame is six bytes: index 0 to 5.
	localparam logic [2:0] FRAME_BYTES = 3'd6;

	localparam logic [2:0] LEN_R1 = 3'd1;
	localparam logic [2:0] LEN_R3 = 3'd5;

	// Configuration register indexes and reset values.
	localparam logic [1:0] CFG_RETRY_LIMIT = 2'd0;
	localparam logic [1:0] CFG_BUSY_LIMIT  = 2'd1;

	localparam logic [7:0]  RETRY_LIMIT_RST = 8'd100;
	localparam logic [12:0] BUSY_LIMIT_RST  = 13'd5000;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_BUSY,
		PH_SEND,
		PH_WAIT,
		PH_REST
	} sdspi_phase_t;

	typedef struct packed {
		logic        mode;
		logic [5:0]  cmd_index;
		logic        is_app_command;
		logic [31:0] argument;
		logic [7:0]  rx_byte;
	} sdspi_in_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  tx_byte;
		logic        select_active;
		logic        failed;
		logic [39:0] response_value;
		logic [2:0]  response_bytes;
	} sdspi_out_t;

	typedef struct packed {
		sdspi_phase_t phase;
		logic [2:0]   byte_cnt;
		logic [5:0]   cmd;
		logic [31:0]  arg;
		logic         prefix;
		logic [12:0]  wait_cnt;
		logic [39:0]  shift;
		logic [2:0]   len;
	} sdspi_state_t;

	// Action chosen by the step logic for the current transaction.
	typedef struct packed {
		logic       xchg;
		logic       finish;
		logic       fail;
		logic [7:0] tx;
	} sdspi_action_t;

	// Byte idx of the command frame for command c with argument a.
	function automatic logic [7:0] frame_byte(input logic [2:0] idx, input logic [5:0] c,
			input logic [31:0] a);
		logic [7:0] b;
		begin
			case (idx)
				3'd0: b = FRAME_START | {2'b00, c};
				3'd1: b = a[31:24];
				3'd2: b = a[23:16];
				3'd3: b = a[15:8];
				3'd4: b = a[7:0];
				default: begin
					if (c == CMD_GO_IDLE && a == 32'd0) b = CRC_GO_IDLE;
					else if (c == CMD_IF_COND && a == IF_COND_ARG) b = CRC_IF_COND;
					else b = CRC_DUMMY;
				end
			endcase
			return b;
		end
	endfunction

endpackage
`default_nettype wire

[hdl/sdspi_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sdspi_step
// Combinational step of the command engine: next state and result for one
// transaction.
// ----------------------------------------------------------------------------
module sdspi_step
	import sdspi_pkg::*;
(
	input  wire sdspi_state_t  st,
	input  wire sdspi_in_t     item,
	input  wire logic [7:0]    retry_limit,
	input  wire logic [12:0]   busy_limit,
	output sdspi_state_t       nxt,
	output logic               res_valid,
	output sdspi_out_t         res
);

	sdspi_action_t act;

	// Next state and action.
	always_comb begin
		logic        go_send;
		logic        go_main;
		logic        go_complete;
		logic [12:0] lim;
		logic [12:0] wc1;
		logic [2:0]  bc1;
		logic [5:0]  cur_cmd;
		logic [31:0] cur_arg;
		nxt         = st;
		act         = '0;
		go_send     = 1'b0;
		go_main     = 1'b0;
		go_complete = 1'b0;
		lim         = (busy_limit == 13'd0) ? 13'd1 : busy_limit;
		wc1         = st.wait_cnt + 13'd1;
		bc1         = st.byte_cnt + 3'd1;
		cur_cmd     = st.prefix ? CMD_APP : st.cmd;
		cur_arg     = st.prefix ? 32'd0 : st.arg;
		if (!item.mode) begin
			nxt.cmd      = item.cmd_index;
			nxt.arg      = item.argument;
			nxt.len      = (item.cmd_index == CMD_IF_COND || item.cmd_index == CMD_GET_OCR)
				? LEN_R3 : LEN_R1;
			nxt.shift    = '0;
			nxt.wait_cnt = '0;
			if (item.is_app_command) begin
				nxt.prefix = 1'b1;
				go_send    = 1'b1;
			end else begin
				go_main = 1'b1;
			end
		end else begin
			unique case (st.phase)
				PH_BUSY: begin
					nxt.wait_cnt = wc1;
					if (item.rx_byte == FILL_BYTE && wc1 < lim) begin
						act.xchg = 1'b1;
						act.tx   = FILL_BYTE;
					end else begin
						go_send = 1'b1;
					end
				end
				PH_SEND: begin
					nxt.byte_cnt = bc1;
					act.xchg     = 1'b1;
					if (bc1 < FRAME_BYTES) begin
						act.tx = frame_byte(bc1, cur_cmd, cur_arg);
					end else begin
						nxt.phase    = PH_WAIT;
						nxt.wait_cnt = '0;
						act.tx       = FILL_BYTE;
					end
				end
				PH_WAIT: begin
					if (!item.rx_byte[7]) begin
						nxt.shift = {32'd0, item.rx_byte};
						if (st.prefix || st.len <= LEN_R1) begin
							go_complete = 1'b1;
						end else begin
							nxt.byte_cnt = st.len - 3'd1;
							nxt.phase    = PH_REST;
							act.xchg     = 1'b1;
							act.tx       = FILL_BYTE;
						end
					end else if (st.wait_cnt >= {5'd0, retry_limit}) begin
						act.finish = 1'b1;
						act.fail   = 1'b1;
					end else begin
						nxt.wait_cnt = wc1;
						act.xchg     = 1'b1;
						act.tx       = FILL_BYTE;
					end
				end
				PH_REST: begin
					nxt.shift    = {st.shift[31:0], item.rx_byte};
					nxt.byte_cnt = st.byte_cnt - 3'd1;
					if (st.byte_cnt == 3'd1) begin
						go_complete = 1'b1;
					end else begin
						act.xchg = 1'b1;
						act.tx   = FILL_BYTE;
					end
				end
				default: begin
					nxt.phase = PH_IDLE;
				end
			endcase
		end

		// After the prefix response the real command follows.
		if (go_complete) begin
			if (nxt.prefix) go_main = 1'b1;
			else act.finish = 1'b1;
		end
		if (go_main) begin
			nxt.prefix = 1'b0;
			if (nxt.cmd == CMD_STOP) begin
				nxt.phase    = PH_BUSY;
				nxt.wait_cnt = '0;
				act.xchg     = 1'b1;
				act.tx       = FILL_BYTE;
			end else begin
				go_send = 1'b1;
			end
		end
		if (go_send) begin
			nxt.phase    = PH_SEND;
			nxt.byte_cnt = '0;
			act.xchg     = 1'b1;
			act.tx       = frame_byte(3'd0, nxt.prefix ? CMD_APP : nxt.cmd, 32'd0);
		end
		if (act.finish) begin
			nxt.phase = PH_IDLE;
		end
	end

	// Result fields.
	always_comb begin
		res_valid          = act.xchg | act.finish;
		res.kind           = act.finish;
		res.tx_byte        = act.finish ? 8'd0 : act.tx;
		res.select_active  = ~act.finish;
		res.failed         = act.finish & act.fail;
		res.response_value = (act.finish && !act.fail) ? nxt.shift : 40'd0;
		res.response_bytes = nxt.len;
	end

endmodule
`default_nettype wire

[hdl/sd_spi_command_engine.sv]
`default_nettype none
// The input register holds each transaction until the result register takes it.
// Throughput: one input transaction per cycle, less when the output stalls;
// the state loop closes through the step logic between the input register and
// the result register. Reset: asynchronous, active low; the engine returns to
// idle and the limits take their reset values (retry 100, busy 5000).
// ----------------------------------------------------------------------------
// sd_spi_command_engine
// Issues one SD card SPI-mode command, one byte exchange or final status per result.
// ----------------------------------------------------------------------------
module sd_spi_command_engine
	import sdspi_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire sdspi_in_t   in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output sdspi_out_t       out_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	// Configuration registers. The user must write them only while the engine is idle;
	// the engine does not enforce this, and writes are always accepted.
	logic [7:0]  retry_limit_q;
	logic [12:0] busy_limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= RETRY_LIMIT_RST;
			busy_limit_q  <= BUSY_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_RETRY_LIMIT: retry_limit_q <= cfg_data[7:0];
				CFG_BUSY_LIMIT:  busy_limit_q  <= cfg_data[12:0];
				default:         ;
			endcase
		end
	end

	// Input register. The stage moves on whenever the result register is
	// empty or is being emptied in this cycle, so a new transaction can be
	// taken every cycle while the consumer keeps up.
	logic       valid_s1;
	sdspi_in_t  item_s1;
	logic       advance;
	logic       out_valid_q;
	sdspi_out_t out_q;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// Engine state and the step logic that advances it.
	sdspi_state_t st_q;
	sdspi_state_t st_nxt;
	logic         res_valid;
	sdspi_out_t   res;

	sdspi_step u_step (
		.st          (st_q),
		.item        (item_s1),
		.retry_limit (retry_limit_q),
		.busy_limit  (busy_limit_q),
		.nxt         (st_nxt),
		.res_valid   (res_valid),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase    <= PH_IDLE;
			st_q.byte_cnt <= '0;
			st_q.cmd      <= '0;
			st_q.arg      <= '0;
			st_q.prefix   <= 1'b0;
			st_q.wait_cnt <= '0;
			st_q.shift    <= '0;
			st_q.len      <= LEN_R1;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	// Result register. A byte that arrives while idle produces no result,
	// so the register is only loaded when the step logic asks for it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// A finish transaction never drives the bus.
	a_finish_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.kind |-> !out_q.select_active && out_q.tx_byte == 8'd0)
		else $error("finish result drives the bus");

	// A timed out command reports no response data.
	a_fail_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.failed |-> out_q.kind && out_q.response_value == 40'd0)
		else $error("failed result carries response data");

	// The response length is one of the two supported formats.
	a_len_legal: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.len == LEN_R1 || st_q.len == LEN_R3)
		else $error("illegal response length");

	// While reading the tail of a long response the count stays in range.
	a_rest_count: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == PH_REST |-> st_q.byte_cnt != 3'd0 && st_q.byte_cnt <= 3'd4)
		else $error("response byte count out of range");

	// A result can only be loaded when the input stage actually advances.
	a_load_src: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(out_valid_q) && !$past(advance) && $past(arst_n) |-> !out_valid_q)
		else $error("result appeared without an input transaction");

endmodule
`default_nettype wire

[sim/tb_sd_spi_command_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sd_spi_command_engine
// Self-checking bench for the SD card SPI-mode command engine. A card model
// answers every byte exchange using the predicted engine state, and a
// scoreboard predicts each result and checks it field by field.
// ----------------------------------------------------------------------------
import sdspi_pkg::*;

class spi_command_scoreboard;
	logic [7:0]   retry_limit;
	logic [12:0]  busy_limit;
	sdspi_phase_t phase;
	logic [2:0]   byte_cnt;
	logic [5:0]   cmd;
	logic [31:0]  arg;
	logic         prefix_due;
	logic [12:0]  wait_cnt;
	logic [39:0]  resp_shift;
	logic [2:0]   resp_len;
	sdspi_out_t   expected_xfers[$];
	int           failures;

	function new();
		retry_limit = RETRY_LIMIT_RST;
		busy_limit  = BUSY_LIMIT_RST;
		phase       = PH_IDLE;
		byte_cnt    = '0;
		cmd         = '0;
		arg         = '0;
		prefix_due  = 1'b0;
		wait_cnt    = '0;
		resp_shift  = '0;
		resp_len    = LEN_R1;
		failures    = 0;
	endfunction

	function void write_register(logic [1:0] idx, logic [15:0] value);
		case (idx)
			CFG_RETRY_LIMIT: retry_limit = value[7:0];
			CFG_BUSY_LIMIT: busy_limit = value[12:0];
			default: ;
		endcase
	endfunction

	// Byte i of the frame on the wire; the CMD55 prefix always has argument 0.
	function logic [7:0] frame_at(logic [2:0] i);
		logic [5:0]  c;
		logic [31:0] a;
		c = prefix_due ? CMD_APP : cmd;
		a = prefix_due ? 32'd0 : arg;
		if (i == 3'd0)
			return FRAME_START | {2'b00, c};
		if (i <= 3'd4)
			return 8'(a >> (8 * (4 - int'(i))));
		if (c == CMD_GO_IDLE && a == 32'd0)
			return CRC_GO_IDLE;
		if (c == CMD_IF_COND && a == IF_COND_ARG)
			return CRC_IF_COND;
		return CRC_DUMMY;
	endfunction

	function void push_exchange(logic [7:0] tx);
		sdspi_out_t r;
		r = '0;
		r.tx_byte = tx;
		r.select_active = 1'b1;
		r.response_bytes = resp_len;
		expected_xfers.push_back(r);
	endfunction

	function void push_finish(bit timed_out);
		sdspi_out_t r;
		r = '0;
		r.kind = 1'b1;
		r.failed = timed_out;
		r.response_value = timed_out ? 40'd0 : resp_shift;
		r.response_bytes = resp_len;
		expected_xfers.push_back(r);
		phase = PH_IDLE;
	endfunction

	function void open_frame();
		phase = PH_SEND;
		byte_cnt = '0;
		push_exchange(frame_at(3'd0));
	endfunction

	// The real command: a stop command first waits out the card's busy state.
	function void open_main();
		prefix_due = 1'b0;
		if (cmd == CMD_STOP) begin
			phase = PH_BUSY;
			wait_cnt = '0;
			push_exchange(FILL_BYTE);
		end else begin
			open_frame();
		end
	endfunction

	function void response_done();
		if (prefix_due)
			open_main();
		else
			push_finish(1'b0);
	endfunction

	function void accept_input(sdspi_in_t t);
		logic [12:0] lim;
		logic [2:0]  need;
		if (!t.mode) begin
			cmd = t.cmd_index;
			arg = t.argument;
			resp_len = (cmd == CMD_IF_COND || cmd == CMD_GET_OCR) ? LEN_R3 : LEN_R1;
			resp_shift = '0;
			wait_cnt = '0;
			if (t.is_app_command) begin
				prefix_due = 1'b1;
				open_frame();
			end else begin
				open_main();
			end
			return;
		end
		case (phase)
			PH_BUSY: begin
				lim = (busy_limit == 13'd0) ? 13'd1 : busy_limit;
				wait_cnt = wait_cnt + 13'd1;
				if (t.rx_byte == FILL_BYTE && wait_cnt < lim)
					push_exchange(FILL_BYTE);
				else
					open_frame();
			end
			PH_SEND: begin
				byte_cnt = byte_cnt + 3'd1;
				if (byte_cnt < FRAME_BYTES) begin
					push_exchange(frame_at(byte_cnt));
				end else begin
					phase = PH_WAIT;
					wait_cnt = '0;
					push_exchange(FILL_BYTE);
				end
			end
			PH_WAIT: begin
				if (!t.rx_byte[7]) begin
					need = prefix_due ? LEN_R1 : resp_len;
					resp_shift = {32'd0, t.rx_byte};
					if (need <= 3'd1) begin
						response_done();
					end else begin
						byte_cnt = need - 3'd1;
						phase = PH_REST;
						push_exchange(FILL_BYTE);
					end
				end else if (wait_cnt >= {5'd0, retry_limit}) begin
					push_finish(1'b1);
				end else begin
					wait_cnt = wait_cnt + 13'd1;
					push_exchange(FILL_BYTE);
				end
			end
			PH_REST: begin
				resp_shift = {resp_shift[31:0], t.rx_byte};
				byte_cnt = byte_cnt - 3'd1;
				if (byte_cnt == 3'd0)
					response_done();
				else
					push_exchange(FILL_BYTE);
			end
			default: phase = PH_IDLE;
		endcase
	endfunction

	function string show(sdspi_out_t r);
		return $sformatf("kind=%0d tx=%02h sel=%0d failed=%0d value=%010h bytes=%0d",
			r.kind, r.tx_byte, r.select_active, r.failed, r.response_value,
			r.response_bytes);
	endfunction

	function void check_result(sdspi_out_t got);
		sdspi_out_t want;
		if (expected_xfers.size() == 0) begin
			failures++;
			if (failures <= 10)
				$display("ERROR: result with nothing expected: %s", show(got));
			return;
		end
		want = expected_xfers.pop_front();
		if (got.kind !== want.kind || got.tx_byte !== want.tx_byte ||
				got.select_active !== want.select_active || got.failed !== want.failed ||
				got.response_value !== want.response_value ||
				got.response_bytes !== want.response_bytes) begin
			failures++;
			if (failures <= 10) begin
				$display("ERROR: mismatch at %0t", $realtime);
				$display("  expected %s", show(want));
				$display("  actual   %s", show(got));
			end
		end
	endfunction
endclass

module tb_sd_spi_command_engine;

	localparam int CLK_PERIOD   = 8;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_CYCLES   = 1_000_000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	sdspi_in_t   in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	sdspi_out_t  out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	spi_command_scoreboard sb;

	// Count of input transactions that the engine acts on; bytes it ignores
	// while idle are left out.
	int          items_sent = 0;
	int unsigned cycle_count = 0;
	int          stall_left = 0;

	// Quiet flags switch off idling on one side for a whole stretch of the run.
	bit in_quiet = 1'b0;
	bit out_quiet = 1'b0;

	// Per-command card behavior: a stuck card holds busy or never starts its
	// response, so the engine runs into its limits.
	bit busy_stuck = 1'b0;
	bit resp_stuck = 1'b0;

	sd_spi_command_engine i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Watchdog: a hung handshake or a missing result ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= MAX_CYCLES) begin
			$display("tb_sd_spi_command_engine failed");
			$finish;
		end
	end

	// Result side. Every transaction taken from the engine is checked against
	// the oldest prediction. The ready line stalls at random: mostly short
	// stalls, now and then a long one, and none at all while out_quiet is set.
	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_result(out_data);
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if (!out_quiet && $urandom_range(0, 4) == 0) begin
			out_ready <= 1'b0;
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
				: $urandom_range(0, 2);
		end else begin
			out_ready <= 1'b1;
		end
	end

	function automatic int pick_gap();
		int r;
		if (in_quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// A start transaction; the byte field is a don't-care and is randomized.
	function automatic sdspi_in_t start_item(logic [5:0] c, logic app, logic [31:0] a);
		sdspi_in_t t;
		t.mode = 1'b0;
		t.cmd_index = c;
		t.is_app_command = app;
		t.argument = a;
		t.rx_byte = 8'($urandom);
		return t;
	endfunction

	// A card byte; the command fields are don't-cares and are randomized.
	function automatic sdspi_in_t byte_item(logic [7:0] rx);
		sdspi_in_t t;
		t.mode = 1'b1;
		t.cmd_index = 6'($urandom);
		t.is_app_command = 1'($urandom);
		t.argument = $urandom;
		t.rx_byte = rx;
		return t;
	endfunction

	// Commands are weighted toward the ones the engine treats specially:
	// GO_IDLE and IF_COND with their fixed CRCs, the stop command with its
	// busy wait, CMD58 with a long response, and an explicit CMD55.
	function automatic sdspi_in_t random_start();
		logic [5:0]  c;
		logic [31:0] a;
		a = $urandom;
		if ($urandom_range(0, 7) == 0)
			a = '0;
		else if ($urandom_range(0, 7) == 0)
			a = '1;
		case ($urandom_range(0, 9))
			0: begin
				c = CMD_GO_IDLE;
				if ($urandom_range(0, 1) == 0)
					a = '0;
			end
			1: begin
				c = CMD_IF_COND;
				if ($urandom_range(0, 1) == 0)
					a = IF_COND_ARG;
			end
			2, 3: c = CMD_STOP;
			4: c = CMD_GET_OCR;
			5: c = CMD_APP;
			default: c = 6'($urandom);
		endcase
		return start_item(c, $urandom_range(0, 2) == 0, a);
	endfunction

	// The card's answer to the exchange the engine is predicted to be in.
	function automatic logic [7:0] card_reply();
		logic [7:0] b;
		b = 8'($urandom);
		if (!busy_stuck && !resp_stuck && $urandom_range(0, 9) == 0)
			return b;
		case (sb.phase)
			PH_BUSY: return (busy_stuck || $urandom_range(0, 3) != 0) ? FILL_BYTE : b;
			PH_WAIT: return (resp_stuck || $urandom_range(0, 2) == 0) ? (b | 8'h80)
				: (b & 8'h7F);
			default: return b;
		endcase
	endfunction

	// Drives one input transaction and waits until the engine takes it. The
	// valid line is only lowered when a gap comes before this transaction,
	// so back-to-back transactions keep it high.
	task automatic send_item(input sdspi_in_t item);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (!in_ready);
		if (!item.mode || sb.phase != PH_IDLE)
			items_sent++;
		sb.accept_input(item);
	endtask

	// Waits until every predicted result has come back, then lets the
	// pipeline empty, since an ignored byte may still be on its way through.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.expected_xfers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes both limits while the engine is idle. The upper data bits are
	// random; the engine keeps only the register's width.
	task automatic load_limits(input logic [7:0] retry, input logic [12:0] busy);
		logic [15:0] word;
		settle();
		word = {8'($urandom), retry};
		cfg_valid <= 1'b1;
		cfg_index <= CFG_RETRY_LIMIT;
		cfg_data <= word;
		do @(posedge clk); while (!cfg_ready);
		sb.write_register(CFG_RETRY_LIMIT, word);
		word = {3'($urandom), busy};
		cfg_index <= CFG_BUSY_LIMIT;
		cfg_data <= word;
		do @(posedge clk); while (!cfg_ready);
		sb.write_register(CFG_BUSY_LIMIT, word);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Runs one command to its end with the card model answering. A negative
	// abort count runs it to completion; otherwise it stops after that many
	// card bytes and the next start aborts it. Now and then a random start is
	// slipped in mid-command, which aborts it too and the loop follows the
	// new command.
	task automatic run_command(input logic [5:0] c, input logic app, input logic [31:0] a,
			input int abort_after);
		int n;
		busy_stuck = (sb.busy_limit <= 13'd16) && ($urandom_range(0, 5) == 0);
		resp_stuck = ($urandom_range(0, (sb.retry_limit <= 8'd16) ? 5 : 39) == 0);
		send_item(start_item(c, app, a));
		n = 0;
		while (sb.phase != PH_IDLE && n != abort_after) begin
			if (abort_after < 0 && $urandom_range(0, 59) == 0)
				send_item(random_start());
			else
				send_item(byte_item(card_reply()));
			n++;
		end
	endtask

	// Random commands until about n transactions have been taken, with a
	// stray byte between commands now and then (the engine ignores those).
	task automatic run_random(input int n);
		int        first;
		sdspi_in_t s;
		first = items_sent;
		while (items_sent - first < n) begin
			if ($urandom_range(0, 7) == 0)
				send_item(byte_item(8'($urandom)));
			s = random_start();
			run_command(s.cmd_index, s.is_app_command, s.argument, -1);
		end
	endtask

	initial begin
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset limits: a byte while idle, a start that
		// aborts a running command right away, GO_IDLE cut off after its CRC
		// byte, and IF_COND with its own CRC run to the end.
		send_item(byte_item(8'h00));
		run_command(CMD_GET_OCR, 1'b1, 32'hFFFF_FFFF, 0);
		run_command(CMD_GO_IDLE, 1'b0, 32'd0, 5);
		run_command(CMD_IF_COND, 1'b0, IF_COND_ARG, -1);

		run_random(60);

		// Lowest limits, with a sender that never pauses.
		load_limits(8'd1, 13'd1);
		in_quiet = 1'b1;
		run_random(70);
		in_quiet = 1'b0;

		// Highest limits, with a receiver that never stalls.
		load_limits(8'd255, 13'd8191);
		out_quiet = 1'b1;
		run_random(70);
		out_quiet = 1'b0;

		// A busy limit of zero behaves as one.
		load_limits(8'd3, 13'd0);
		run_random(60);

		load_limits(8'($urandom_range(1, 8)), 13'($urandom_range(1, 12)));
		run_random(70);

		load_limits(8'($urandom_range(1, 255)), 13'($urandom_range(1, 40)));
		run_random(60);

		settle();
		if (sb.failures == 0 && sb.expected_xfers.size() == 0)
			$display("tb_sd_spi_command_engine passed");
		else
			$display("tb_sd_spi_command_engine failed");
		$finish;
	end

endmodule
